// ===== rtl/sfp_pkg.sv =====
package sfp_pkg;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned K_W    = 32;
  localparam int unsigned REST_W = 31;
  localparam int unsigned OUT_W  = 32;

  localparam logic [OUT_W-1:0] FORCE_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] FORCE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic signed [POS_W-1:0] first_x;
    logic signed [POS_W-1:0] first_y;
    logic signed [POS_W-1:0] first_z;
    logic signed [POS_W-1:0] second_x;
    logic signed [POS_W-1:0] second_y;
    logic signed [POS_W-1:0] second_z;
    logic [K_W-1:0]          stiffness;
    logic [REST_W-1:0]       rest_len;
  } sfp_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] force_x;
    logic signed [OUT_W-1:0] force_y;
    logic signed [OUT_W-1:0] force_z;
    logic                    degenerate;
    logic                    saturated;
  } sfp_out_t;

endpackage

// ===== rtl/spring_force_pair.sv =====
// Throughput: one spring per cycle while no result waits untaken; the square root
// takes one root bit per stage and each of the three dividers one quotient bit per stage.
// The whole pipeline advances together and holds while a result waits untaken.
// Reset clears all valid bits; payload registers are not reset.
module spring_force_pair #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sfp_pkg::sfp_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sfp_pkg::sfp_out_t out_data_o
);
  import sfp_pkg::*;

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned ROOT_W = CW + 1;
  localparam int unsigned SUM_W  = 2 * ROOT_W;
  localparam int unsigned SW     = (ROOT_W > REST_W) ? ROOT_W : REST_W;
  localparam int unsigned FW     = SW + K_W - FRAC_BITS;
  localparam int unsigned HI_W   = FW - 32;
  localparam int unsigned NW     = FW + CW;
  localparam int unsigned TOP_W  = NW - 32;
  localparam int unsigned SQ_SIDE = 3 * CW + 3 + K_W + REST_W + 1;

  logic en;
  assign en         = out_ready_i || !out_valid_o;
  assign in_ready_o = en;

  // stage 1: differences
  logic signed [CW:0] dif [3];
  logic [CW-1:0]      mag_d [3];
  logic [2:0]         neg_d;
  logic [63:0]        e1 [3], e2 [3];

  always_comb begin
    e1[0] = 64'(in_data_i.first_x);
    e1[1] = 64'(in_data_i.first_y);
    e1[2] = 64'(in_data_i.first_z);
    e2[0] = 64'(in_data_i.second_x);
    e2[1] = 64'(in_data_i.second_y);
    e2[2] = 64'(in_data_i.second_z);
    for (int i = 0; i < 3; i++) begin
      dif[i]   = $signed({e2[i][CW-1], e2[i][CW-1:0]}) - $signed({e1[i][CW-1], e1[i][CW-1:0]});
      neg_d[i] = dif[i][CW];
      mag_d[i] = neg_d[i] ? CW'(-dif[i]) : dif[i][CW-1:0];
    end
  end

  logic              s1_vld_q;
  logic [CW-1:0]     s1_mag_q [3];
  logic [2:0]        s1_neg_q;
  logic [K_W-1:0]    s1_k_q;
  logic [REST_W-1:0] s1_rest_q;

  // stage 2: squares
  logic              s2_vld_q;
  logic [2*CW-1:0]   s2_sq_q [3];
  logic [CW-1:0]     s2_mag_q [3];
  logic [2:0]        s2_neg_q;
  logic [K_W-1:0]    s2_k_q;
  logic [REST_W-1:0] s2_rest_q;

  // stage 3: sum of squares
  logic              s3_vld_q;
  logic [SUM_W-1:0]  s3_sum_q;
  logic [CW-1:0]     s3_mag_q [3];
  logic [2:0]        s3_neg_q;
  logic [K_W-1:0]    s3_k_q;
  logic [REST_W-1:0] s3_rest_q;
  logic              s3_zero_q;
  logic [SUM_W-1:0]  sum_d;

  assign sum_d = SUM_W'(s2_sq_q[0]) + SUM_W'(s2_sq_q[1]) + SUM_W'(s2_sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mag_q  <= mag_d;
      s1_neg_q  <= neg_d;
      s1_k_q    <= in_data_i.stiffness;
      s1_rest_q <= in_data_i.rest_len;
      for (int i = 0; i < 3; i++) begin
        s2_sq_q[i] <= s1_mag_q[i] * s1_mag_q[i];
      end
      s2_mag_q  <= s1_mag_q;
      s2_neg_q  <= s1_neg_q;
      s2_k_q    <= s1_k_q;
      s2_rest_q <= s1_rest_q;
      s3_sum_q  <= sum_d;
      s3_zero_q <= (sum_d == '0);
      s3_mag_q  <= s2_mag_q;
      s3_neg_q  <= s2_neg_q;
      s3_k_q    <= s2_k_q;
      s3_rest_q <= s2_rest_q;
    end
  end

  // square root
  logic               sq_vld;
  logic [ROOT_W-1:0]  len;
  logic [SQ_SIDE-1:0] sq_side;
  logic [CW-1:0]      sq_mag [3];
  logic [2:0]         sq_neg;
  logic [K_W-1:0]     sq_k;
  logic [REST_W-1:0]  sq_rest;
  logic               sq_zero;

  sfp_isqrt #(
    .ROOT_W (ROOT_W),
    .SIDE_W (SQ_SIDE)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .sum_i   (s3_sum_q),
    .side_i  ({s3_mag_q[0], s3_mag_q[1], s3_mag_q[2], s3_neg_q, s3_k_q, s3_rest_q,
               s3_zero_q}),
    .valid_o (sq_vld),
    .root_o  (len),
    .side_o  (sq_side)
  );

  assign {sq_mag[0], sq_mag[1], sq_mag[2], sq_neg, sq_k, sq_rest, sq_zero} = sq_side;

  // stage 4: stretch
  logic              s4_vld_q, s4_sneg_q, s4_zero_q;
  logic [SW-1:0]     s4_smag_q;
  logic [ROOT_W-1:0] s4_len_q;
  logic [CW-1:0]     s4_mag_q [3];
  logic [2:0]        s4_neg_q;
  logic [K_W-1:0]    s4_k_q;
  logic [SW-1:0]     len_x, rest_x;

  assign len_x  = SW'(len);
  assign rest_x = SW'(sq_rest);

  // stage 5: stretch times stiffness
  logic              s5_vld_q, s5_sneg_q, s5_zero_q;
  logic [SW+K_W-1:0] s5_prod_q;
  logic [ROOT_W-1:0] s5_len_q;
  logic [CW-1:0]     s5_mag_q [3];
  logic [2:0]        s5_neg_q;
  logic [FW-1:0]     fmag;

  assign fmag = s5_prod_q[SW+K_W-1:FRAC_BITS];

  // stage 6: partial products of force times component
  logic              s6_vld_q, s6_zero_q;
  logic [CW+31:0]    s6_plo_q [3];
  logic [HI_W+CW-1:0] s6_phi_q [3];
  logic [ROOT_W-1:0] s6_len_q;
  logic [2:0]        s6_n_q;

  // stage 7: numerator and range check
  logic              s7_vld_q, s7_zero_q;
  logic [NW-1:0]     s7_num_q [3];
  logic [2:0]        s7_ovf_q, s7_n_q;
  logic [ROOT_W-1:0] s7_len_q;
  logic [NW-1:0]     num_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_d[i] = NW'(s6_plo_q[i]) + NW'({s6_phi_q[i], 32'b0});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
      s7_vld_q <= 1'b0;
    end else if (en) begin
      s4_vld_q <= sq_vld;
      s5_vld_q <= s4_vld_q;
      s6_vld_q <= s5_vld_q;
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_sneg_q <= len_x < rest_x;
      s4_smag_q <= (len_x < rest_x) ? rest_x - len_x : len_x - rest_x;
      s4_len_q  <= len;
      s4_mag_q  <= sq_mag;
      s4_neg_q  <= sq_neg;
      s4_k_q    <= sq_k;
      s4_zero_q <= sq_zero;

      s5_prod_q <= s4_smag_q * s4_k_q;
      s5_sneg_q <= s4_sneg_q;
      s5_len_q  <= s4_len_q;
      s5_mag_q  <= s4_mag_q;
      s5_neg_q  <= s4_neg_q;
      s5_zero_q <= s4_zero_q;

      for (int i = 0; i < 3; i++) begin
        s6_plo_q[i] <= fmag[31:0] * s5_mag_q[i];
        s6_phi_q[i] <= fmag[FW-1:32] * s5_mag_q[i];
        s6_n_q[i]   <= s5_sneg_q ^ s5_neg_q[i];
      end
      s6_len_q  <= s5_len_q;
      s6_zero_q <= s5_zero_q;

      for (int i = 0; i < 3; i++) begin
        s7_num_q[i] <= num_d[i];
        s7_ovf_q[i] <= num_d[i][NW-1:32] >= TOP_W'(s6_len_q);
      end
      s7_n_q    <= s6_n_q;
      s7_len_q  <= s6_len_q;
      s7_zero_q <= s6_zero_q;
    end
  end

  // dividers, one per axis
  logic        dv_vld [3];
  logic [31:0] quo [3];
  logic [2:0]  dv_side [3];

  for (genvar a = 0; a < 3; a++) begin : g_div
    sfp_div #(
      .D_W    (ROOT_W),
      .SIDE_W (3)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (s7_vld_q),
      .rem_i   (s7_num_q[a][32 +: ROOT_W]),
      .low_i   (s7_num_q[a][31:0]),
      .den_i   (s7_len_q),
      .side_i  ({s7_zero_q, s7_n_q[a], s7_ovf_q[a]}),
      .valid_o (dv_vld[a]),
      .quo_o   (quo[a]),
      .side_o  (dv_side[a])
    );
  end

  // final stage: sign and clamp
  logic [OUT_W-1:0] f_d [3];
  logic [2:0]       sat_d;
  logic             zero_d;

  always_comb begin
    zero_d = dv_side[0][2];
    for (int i = 0; i < 3; i++) begin
      sat_d[i] = 1'b0;
      f_d[i]   = '0;
      if (zero_d) begin
        f_d[i] = '0;
      end else if (dv_side[i][1] && (dv_side[i][0] || quo[i] != '0)) begin
        if (dv_side[i][0] || quo[i] > FORCE_MIN) begin
          sat_d[i] = 1'b1;
          f_d[i]   = FORCE_MIN;
        end else begin
          f_d[i] = -quo[i];
        end
      end else begin
        if (dv_side[i][0] || quo[i] > FORCE_MAX) begin
          sat_d[i] = 1'b1;
          f_d[i]   = FORCE_MAX;
        end else begin
          f_d[i] = quo[i];
        end
      end
    end
  end

  logic     out_vld_q;
  sfp_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.force_x    <= f_d[0];
      out_q.force_y    <= f_d[1];
      out_q.force_z    <= f_d[2];
      out_q.degenerate <= zero_d;
      out_q.saturated  <= |sat_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_degenerate_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |-> out_data_o.force_x == '0 &&
      out_data_o.force_y == '0 && out_data_o.force_z == '0 && !out_data_o.saturated)
    else $error("degenerate result with nonzero force");

  a_sat_at_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.force_x == FORCE_MAX || out_data_o.force_x == FORCE_MIN ||
      out_data_o.force_y == FORCE_MAX || out_data_o.force_y == FORCE_MIN ||
      out_data_o.force_z == FORCE_MAX || out_data_o.force_z == FORCE_MIN)
    else $error("saturated flag without a clamped component");

  a_stall_only_on_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("pipeline stalled with no waiting result");

  a_lanes_in_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld[0] == dv_vld[1] && dv_vld[1] == dv_vld[2])
    else $error("divider lanes out of step");

endmodule

// ===== rtl/sfp_isqrt.sv =====
module sfp_isqrt #(
  parameter int unsigned ROOT_W = 33,
  parameter int unsigned SIDE_W = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [2*ROOT_W-1:0]   sum_i,
  input  logic [SIDE_W-1:0]     side_i,
  output logic                  valid_o,
  output logic [ROOT_W-1:0]     root_o,
  output logic [SIDE_W-1:0]     side_o
);

  localparam int unsigned SUM_W = 2 * ROOT_W;
  localparam int unsigned RW    = ROOT_W + 3;

  logic [SUM_W-1:0]  s_w    [ROOT_W+1];
  logic [RW-1:0]     rem_w  [ROOT_W+1];
  logic [ROOT_W-1:0] root_w [ROOT_W+1];
  logic [SIDE_W-1:0] side_w [ROOT_W+1];
  logic [ROOT_W:0]   vld_w;

  assign s_w[0]    = sum_i;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign side_w[0] = side_i;
  assign vld_w[0]  = valid_i;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic [RW-1:0]     rem2, trial, rem_d;
    logic              ge;
    logic [SUM_W-1:0]  s_q;
    logic [RW-1:0]     rem_q;
    logic [ROOT_W-1:0] root_q;
    logic [SIDE_W-1:0] side_q;
    logic              vld_q;

    always_comb begin
      rem2  = {rem_w[i][RW-3:0], s_w[i][SUM_W-1 -: 2]};
      trial = RW'({root_w[i], 2'b01});
      ge    = rem2 >= trial;
      rem_d = ge ? rem2 - trial : rem2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q    <= {s_w[i][SUM_W-3:0], 2'b00};
        rem_q  <= rem_d;
        root_q <= {root_w[i][ROOT_W-2:0], ge};
        side_q <= side_w[i];
      end
    end

    assign s_w[i+1]    = s_q;
    assign rem_w[i+1]  = rem_q;
    assign root_w[i+1] = root_q;
    assign side_w[i+1] = side_q;
    assign vld_w[i+1]  = vld_q;
  end

  assign valid_o = vld_w[ROOT_W];
  assign root_o  = root_w[ROOT_W];
  assign side_o  = side_w[ROOT_W];

endmodule

// ===== rtl/sfp_div.sv =====
module sfp_div #(
  parameter int unsigned D_W    = 33,
  parameter int unsigned SIDE_W = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [D_W-1:0]    rem_i,
  input  logic [31:0]       low_i,
  input  logic [D_W-1:0]    den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [31:0]       quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned Q_W = 32;

  logic [D_W-1:0]    rem_w  [Q_W+1];
  logic [Q_W-1:0]    low_w  [Q_W+1];
  logic [D_W-1:0]    den_w  [Q_W+1];
  logic [Q_W-1:0]    quo_w  [Q_W+1];
  logic [SIDE_W-1:0] side_w [Q_W+1];
  logic [Q_W:0]      vld_w;

  assign rem_w[0]  = rem_i;
  assign low_w[0]  = low_i;
  assign den_w[0]  = den_i;
  assign quo_w[0]  = '0;
  assign side_w[0] = side_i;
  assign vld_w[0]  = valid_i;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [D_W:0]      t, diff;
    logic              ge;
    logic [D_W-1:0]    rem_q, den_q;
    logic [Q_W-1:0]    low_q, quo_q;
    logic [SIDE_W-1:0] side_q;
    logic              vld_q;

    always_comb begin
      t    = {rem_w[i], low_w[i][Q_W-1]};
      ge   = t >= {1'b0, den_w[i]};
      diff = t - {1'b0, den_w[i]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= ge ? diff[D_W-1:0] : t[D_W-1:0];
        low_q  <= {low_w[i][Q_W-2:0], 1'b0};
        den_q  <= den_w[i];
        quo_q  <= {quo_w[i][Q_W-2:0], ge};
        side_q <= side_w[i];
      end
    end

    assign rem_w[i+1]  = rem_q;
    assign low_w[i+1]  = low_q;
    assign den_w[i+1]  = den_q;
    assign quo_w[i+1]  = quo_q;
    assign side_w[i+1] = side_q;
    assign vld_w[i+1]  = vld_q;
  end

  assign valid_o = vld_w[Q_W];
  assign quo_o   = quo_w[Q_W];
  assign side_o  = side_w[Q_W];

endmodule
